/* rtl/fpa_pkg.sv */
// Package for the fixed-point ALU: operation codes and default sizes.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [3:0] {
		OP_ADD    = 4'd0,
		OP_SUB    = 4'd1,
		OP_MUL    = 4'd2,
		OP_DIV    = 4'd3,
		OP_INC    = 4'd4,
		OP_DEC    = 4'd5,
		OP_GT     = 4'd6,
		OP_LT     = 4'd7,
		OP_EQ     = 4'd8,
		OP_GE     = 4'd9,
		OP_LE     = 4'd10,
		OP_NE     = 4'd11,
		OP_MIN    = 4'd12,
		OP_MAX    = 4'd13,
		OP_TO_INT = 4'd14
	} op_t;

endpackage
`default_nettype wire

/* rtl/fixed_point_alu.sv */
// Pipelined signed fixed-point ALU with a bit-per-stage divider.
//
// Command channel: an operation and two raw fixed-point operands transfer
// at a rising edge where start is high and busy is low. busy never rises,
// so a new command may be issued in every cycle.
// Result channel: done is high for exactly one cycle with result_value,
// compare_true, overflow and divide_by_zero; the receiver cannot stall it.
// Results leave in command order.
// Every operation passes the input register, the chain and the output
// register in turn (the default format is Q24.8): the divider chain
// retires one quotient bit per stage and all operations ride the same
// chain. Throughput: one command per cycle.
// Only the low WORD_BITS bits of each operand are used; result_value is
// sign-extended to 32 bits.
// Reset clears all valid bits; no result is lost or repeated since the
// pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [3:0]         operation,
	input  wire logic signed [31:0] operand_a,
	input  wire logic signed [31:0] operand_b,
	output logic                    done,
	output logic signed [31:0]      result_value,
	output logic                    compare_true,
	output logic                    overflow,
	output logic                    divide_by_zero
);
	import fpa_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int QB = W + F;

	localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [2*W-1:0] ONE_P  = 1;
	localparam logic [2*W-1:0] HALF_P = ONE_P << (F - 1);
	localparam logic [2*W-1:0] LIM_P  = ONE_P << (W - 1);
	localparam logic [QB:0]    ONE_Q  = 1;
	localparam logic [QB:0]    LIM_Q  = ONE_Q << (W - 1);

	function automatic logic [W:0] sat(input logic signed [W:0] v);
		logic o;
		o = v[W] != v[W-1];
		return o ? {1'b1, (v[W] ? W_MIN : W_MAX)} : {1'b0, v[W-1:0]};
	endfunction

	// input register
	logic                v_s1;
	op_t                 op_s1;
	logic signed [W-1:0] a_s1, b_s1;

	// chain: index 0 is stage 2, index QB feeds the output register
	logic [QB:0]         v_s;
	logic [QB:0]         mul_s, div_s, cmp_s, ovf_s, dz_s, qneg_s;
	logic signed [W-1:0] res_s  [0:QB];
	logic [W-1:0]        den_s  [0:QB];
	logic [W-1:0]        rem_s  [0:QB];
	logic [QB-1:0]       nq_s   [0:QB];

	logic signed [2*W-1:0] prod_s2;
	logic [2*W-1:0]        pmag_s3;
	logic                  pneg_s3;

	// stage 2 combinational
	logic signed [W-1:0] n_res;
	logic                n_cmp, n_ovf, n_dz, n_div, n_mul;
	logic [W:0]          s_add, s_sub, s_inc, s_dec;
	logic [W-1:0]        amag, bmag, tmag;

	always_comb begin
		n_res = '0;
		n_cmp = 1'b0;
		n_ovf = 1'b0;
		n_dz  = 1'b0;
		n_div = 1'b0;
		n_mul = 1'b0;
		s_add = sat({a_s1[W-1], a_s1} + {b_s1[W-1], b_s1});
		s_sub = sat({a_s1[W-1], a_s1} - {b_s1[W-1], b_s1});
		s_inc = sat({a_s1[W-1], a_s1} + (W+1)'(1));
		s_dec = sat({a_s1[W-1], a_s1} - (W+1)'(1));
		amag  = a_s1[W-1] ? W'(-a_s1) : W'(a_s1);
		bmag  = b_s1[W-1] ? W'(-b_s1) : W'(b_s1);
		tmag  = amag >> F;
		unique case (op_s1)
			OP_ADD: begin
				n_res = s_add[W-1:0];
				n_ovf = s_add[W];
			end
			OP_SUB: begin
				n_res = s_sub[W-1:0];
				n_ovf = s_sub[W];
			end
			OP_MUL: n_mul = 1'b1;
			OP_DIV: begin
				if (b_s1 == '0) begin
					n_dz  = 1'b1;
					n_res = a_s1[W-1] ? W_MIN : W_MAX;
				end else begin
					n_div = 1'b1;
				end
			end
			OP_INC: begin
				n_res = s_inc[W-1:0];
				n_ovf = s_inc[W];
			end
			OP_DEC: begin
				n_res = s_dec[W-1:0];
				n_ovf = s_dec[W];
			end
			OP_GT:     n_cmp = a_s1 > b_s1;
			OP_LT:     n_cmp = a_s1 < b_s1;
			OP_EQ:     n_cmp = a_s1 == b_s1;
			OP_GE:     n_cmp = a_s1 >= b_s1;
			OP_LE:     n_cmp = a_s1 <= b_s1;
			OP_NE:     n_cmp = a_s1 != b_s1;
			OP_MIN:    n_res = (a_s1 < b_s1) ? a_s1 : b_s1;
			OP_MAX:    n_res = (a_s1 > b_s1) ? a_s1 : b_s1;
			OP_TO_INT: n_res = a_s1[W-1] ? -$signed(tmag) : $signed(tmag);
			default: ;
		endcase
	end

	// multiply rounding, applied between chain index 1 and 2
	logic [2*W-1:0]      mq;
	logic signed [W-1:0] m_res;
	logic                m_ovf;

	always_comb begin
		mq    = (pmag_s3 + HALF_P) >> F;
		m_ovf = pneg_s3 ? (mq > LIM_P) : (mq >= LIM_P);
		if (m_ovf)
			m_res = pneg_s3 ? W_MIN : W_MAX;
		else
			m_res = pneg_s3 ? -$signed(mq[W-1:0]) : $signed(mq[W-1:0]);
	end

	// divide step per chain index
	logic [W:0]    trial [0:QB-1];
	logic [QB-1:0] qge;

	always_comb begin
		for (int k = 0; k < QB; k++) begin
			trial[k] = {rem_s[k], nq_s[k][QB-1]};
			qge[k]   = trial[k] >= {1'b0, den_s[k]};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s  <= '0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s  <= {v_s[QB-1:0], v_s1};
			done <= v_s[QB];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		op_s1 <= op_t'(operation);
		a_s1  <= $signed(operand_a[W-1:0]);
		b_s1  <= $signed(operand_b[W-1:0]);

		res_s[0]  <= n_res;
		cmp_s[0]  <= n_cmp;
		ovf_s[0]  <= n_ovf;
		dz_s[0]   <= n_dz;
		mul_s[0]  <= n_mul;
		div_s[0]  <= n_div;
		qneg_s[0] <= a_s1[W-1] ^ b_s1[W-1];
		den_s[0]  <= bmag;
		rem_s[0]  <= '0;
		nq_s[0]   <= {amag, {F{1'b0}}};
		prod_s2   <= a_s1 * b_s1;

		pmag_s3 <= prod_s2[2*W-1] ? (2*W)'(-prod_s2) : (2*W)'(prod_s2);
		pneg_s3 <= prod_s2[2*W-1];

		for (int k = 0; k < QB; k++) begin
			cmp_s[k+1]  <= cmp_s[k];
			dz_s[k+1]   <= dz_s[k];
			mul_s[k+1]  <= mul_s[k];
			div_s[k+1]  <= div_s[k];
			qneg_s[k+1] <= qneg_s[k];
			den_s[k+1]  <= den_s[k];
			rem_s[k+1]  <= qge[k] ? W'(trial[k] - {1'b0, den_s[k]}) : trial[k][W-1:0];
			nq_s[k+1]   <= {nq_s[k][QB-2:0], qge[k]};
			if (k == 1 && mul_s[k]) begin
				res_s[k+1] <= m_res;
				ovf_s[k+1] <= m_ovf;
			end else begin
				res_s[k+1] <= res_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// output register with divide rounding
	logic [QB:0]         dq;
	logic                d_ovf;
	logic signed [W-1:0] d_res;

	always_comb begin
		dq    = {1'b0, nq_s[QB]} + (QB+1)'({rem_s[QB], 1'b0} >= {1'b0, den_s[QB]});
		d_ovf = qneg_s[QB] ? (dq > LIM_Q) : (dq >= LIM_Q);
		if (d_ovf)
			d_res = qneg_s[QB] ? W_MIN : W_MAX;
		else
			d_res = qneg_s[QB] ? -$signed(dq[W-1:0]) : $signed(dq[W-1:0]);
	end

	always_ff @(posedge clk) begin
		result_value   <= 32'(div_s[QB] ? d_res : res_s[QB]);
		overflow       <= div_s[QB] ? d_ovf : ovf_s[QB];
		compare_true   <= cmp_s[QB];
		divide_by_zero <= dz_s[QB];
	end

	assign busy = 1'b0;

endmodule
`default_nettype wire

/* test/tb_fixed_point_alu.sv */
// Testbench for fixed_point_alu: directed and randomized command stream checked against an inline predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_fixed_point_alu;
	import fpa_pkg::*;

	localparam int LATENCY = 43;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} alu_cmd_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               cmp;
		logic               ovf;
		logic               dz;
	} alu_res_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [3:0] operation;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic done;
	logic signed [31:0] result_value;
	logic compare_true;
	logic overflow;
	logic divide_by_zero;

	alu_cmd_t pending_cmds[$];
	alu_res_t expected_results[$];
	int error_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int op_hits[16];
	int idle_cycles = 0;
	bit stimulus_done = 0;
	bit hold_for_drain = 0;
	int burst_left = 0;
	int gap_left = 0;

	fixed_point_alu u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .operand_a(operand_a), .operand_b(operand_b),
		.done(done), .result_value(result_value), .compare_true(compare_true),
		.overflow(overflow), .divide_by_zero(divide_by_zero)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint sat32(input longint v, inout logic ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic alu_res_t compute_alu(input alu_cmd_t c);
		alu_res_t res;
		longint a, b, r, p;
		longint unsigned ma, mb, mp, q;
		a = c.a;
		b = c.b;
		r = 0;
		res = '0;
		case (c.op)
			OP_ADD: r = sat32(a + b, res.ovf);
			OP_SUB: r = sat32(a - b, res.ovf);
			OP_MUL: begin
				p = a * b;
				mp = (p < 0) ? -p : p;
				q = (2 * mp + 256) / 512;
				r = sat32((p < 0) ? -longint'(q) : longint'(q), res.ovf);
			end
			OP_DIV: begin
				if (b == 0) begin
					res.dz = 1;
					r = (a < 0) ? -64'sd2147483648 : 64'sd2147483647;
				end else begin
					ma = ((a < 0) ? -a : a) << 8;
					mb = (b < 0) ? -b : b;
					q = (2 * ma + mb) / (2 * mb);
					r = sat32(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), res.ovf);
				end
			end
			OP_INC: r = sat32(a + 1, res.ovf);
			OP_DEC: r = sat32(a - 1, res.ovf);
			OP_GT: res.cmp = a > b;
			OP_LT: res.cmp = a < b;
			OP_EQ: res.cmp = a == b;
			OP_GE: res.cmp = a >= b;
			OP_LE: res.cmp = a <= b;
			OP_NE: res.cmp = a != b;
			OP_MIN: r = (a < b) ? a : b;
			OP_MAX: r = (a > b) ? a : b;
			OP_TO_INT: begin
				ma = (a < 0) ? -a : a;
				r = (a < 0) ? -longint'(ma >> 8) : longint'(ma >> 8);
			end
			default: r = 0;
		endcase
		res.value = r[31:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
			checked_count);
		error_count++;
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff - $urandom_range(0, 3);
			1: return 32'h80000000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 3) - 2;
			3: return ($urandom_range(0, 2000) - 1000) << 8;
			4: return $urandom_range(0, 65535) - 32768;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_cmd(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
		alu_cmd_t c;
		c.op = op;
		c.a = a;
		c.b = b;
		pending_cmds.push_back(c);
	endtask

	// driver: bursts and gaps, one transfer per edge while busy is low, with start held through bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			operation <= '0;
			operand_a <= '0;
			operand_b <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(compute_alu({operation, operand_a, operand_b}));
				op_hits[operation]++;
				sent_count++;
			end
			if (start && busy) begin
				// hold current command
			end else if (pending_cmds.size() > 0 && gap_left == 0 && !hold_for_drain) begin
				alu_cmd_t c;
				c = pending_cmds.pop_front();
				start <= 1;
				operation <= c.op;
				operand_a <= c.a;
				operand_b <= c.b;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				if (burst_left == 0) begin
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				start <= 0;
				if (gap_left > 0) begin
					gap_left--;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				alu_res_t want;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result_value", result_value, 0);
				end else begin
					want = expected_results.pop_front();
					if (result_value !== want.value) begin
						report_mismatch("result_value", result_value, want.value);
					end
					if (compare_true !== want.cmp) begin
						report_mismatch("compare_true", compare_true, want.cmp);
					end
					if (overflow !== want.ovf) begin
						report_mismatch("overflow", overflow, want.ovf);
					end
					if (divide_by_zero !== want.dz) begin
						report_mismatch("divide_by_zero", divide_by_zero, want.dz);
					end
				end
				checked_count++;
			end
			if (done || (start && !busy)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("tb_fixed_point_alu: done, errors");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] edge_vals[6];
		edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h100, 32'hffffff00};
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed: every operation at extremes, div by zero, ties, to_int truncation
		for (int op = 0; op < 16; op++) begin
			queue_cmd(4'(op), edge_vals[op % 6], edge_vals[(op + 1) % 6]);
		end
		queue_cmd(OP_DIV, 32'h7fffffff, 32'h0);
		queue_cmd(OP_DIV, 32'h80000000, 32'h0);
		queue_cmd(OP_DIV, 32'h7fffffff, 32'h1);
		queue_cmd(OP_MUL, 32'h80, 32'h1);
		queue_cmd(OP_MUL, 32'hffffff80, 32'h1);
		queue_cmd(OP_INC, 32'h7fffffff, 32'h0);
		queue_cmd(OP_DEC, 32'h80000000, 32'h0);
		queue_cmd(OP_TO_INT, 32'hfffffe80, 32'h0);
		queue_cmd(OP_EQ, 32'h12345678, 32'h12345678);

		for (int i = 0; i < 300; i++) begin
			queue_cmd(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
		end
		wait (pending_cmds.size() == 0);
		// drain fully once before continuing
		hold_for_drain = 1;
		wait (expected_results.size() == 0 && !start);
		hold_for_drain = 0;
		for (int i = 0; i < 300; i++) begin
			queue_cmd(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
		end
		wait (pending_cmds.size() == 0);
		@(posedge clk);
		wait (expected_results.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("covered %0d commands, %0d results; div %0d, mul %0d, to_int %0d",
			sent_count, checked_count, op_hits[OP_DIV], op_hits[OP_MUL], op_hits[OP_TO_INT]);
		if (error_count == 0) begin
			$display("tb_fixed_point_alu: done, clean");
		end else begin
			$display("tb_fixed_point_alu: done, errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
